// File: sv/wsn_pkg.sv
// Shared constants, item types and divider interface types for the weighted share normalizer.
package wsn_pkg;

    localparam int MAX_GROUPS  = 64;
    localparam int PHASE_COUNT = 4;

    localparam int PHASE_W  = 3;
    localparam int WEIGHT_W = 16;
    localparam int PWR_W    = 24;
    localparam int PROD_W   = 40;
    localparam int TOT_W    = 47;
    localparam int SHARE_W  = 32;
    localparam int GIDX_W   = 6;
    localparam int FRAC_W   = 16;
    localparam int QUO_W    = 2 * FRAC_W;

    localparam int DIGIT_W     = 4;
    localparam int DIGITS      = WEIGHT_W / DIGIT_W;
    localparam int DIGIT_CNT_W = $clog2(DIGITS);
    localparam int PART_W      = DIGIT_W + 1 + PWR_W;

    localparam int IDX_W   = $clog2(MAX_GROUPS);
    localparam int CNT_W   = $clog2(MAX_GROUPS + 1);
    localparam int STORE_W = 2 * PROD_W;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 64;
    localparam int REG_SHIFT  = 3;
    localparam int REG_IDX_W  = CFG_ADDR_W - REG_SHIFT;

    localparam logic [REG_IDX_W-1:0] REG_ZERO_BAND = '0;

    typedef struct packed {
        logic [PHASE_W-1:0]      phase;
        logic [WEIGHT_W-1:0]     weight;
        logic signed [PWR_W-1:0] active_power;
        logic signed [PWR_W-1:0] reactive_power;
        logic                    last;
    } load_t;

    typedef struct packed {
        logic [GIDX_W-1:0]         group_index;
        logic [PHASE_W-1:0]        set_phase;
        logic signed [SHARE_W-1:0] active_share;
        logic signed [SHARE_W-1:0] reactive_share;
        logic                      error;
        logic                      last_out;
    } share_t;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] mag;
        logic              neg;
        logic [TOT_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                      done;
        logic signed [SHARE_W-1:0] q;
    } div_rsp_t;

endpackage

// File: sv/wsn_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module wsn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: sv/wsn_div.sv
// Bit-serial restoring divider that turns a weighted product and a total into a saturated Q16.16 share.
module wsn_div (
    input  logic              clk,
    input  logic              rst_n,
    input  wsn_pkg::div_req_t req,
    output wsn_pkg::div_rsp_t rsp
);
    import wsn_pkg::*;

    localparam int QCNT_W = $clog2(QUO_W);

    logic [TOT_W-1:0]  rem_reg, rem_next;
    logic [QUO_W-1:0]  dvd_reg, dvd_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [TOT_W-1:0]  div_reg, div_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              ovf_reg, ovf_next;
    logic              neg_reg, neg_next;

    logic [TOT_W:0]              trial;
    logic [TOT_W:0]              diff;
    logic                        fits;
    logic [PROD_W-FRAC_W-1:0]    hi_part;
    logic                        sat;
    logic signed [SHARE_W-1:0]   q_val;

    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        ovf_next  = ovf_reg;
        neg_next  = neg_reg;

        hi_part = req.mag[PROD_W-1:FRAC_W];
        trial   = {rem_reg, dvd_reg[QUO_W-1]};
        diff    = trial - {1'b0, div_reg};
        fits    = trial >= {1'b0, div_reg};

        if (req.start)
        begin
            // The quotient reaches 2^32 exactly when the upper dividend part is not below the divisor.
            rem_next  = TOT_W'(hi_part);
            ovf_next  = TOT_W'(hi_part) >= req.divisor;
            dvd_next  = {req.mag[FRAC_W-1:0], {(QUO_W-FRAC_W){1'b0}}};
            quo_next  = '0;
            div_next  = req.divisor;
            neg_next  = req.neg;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[TOT_W-1:0] : trial[TOT_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], fits};
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == QCNT_W'(QUO_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (neg_reg)
        begin
            sat   = ovf_reg || (quo_reg > {1'b1, {(QUO_W-1){1'b0}}});
            q_val = sat ? $signed({1'b1, {(SHARE_W-1){1'b0}}}) : -$signed(quo_reg);
        end
        else
        begin
            sat   = ovf_reg || quo_reg[QUO_W-1];
            q_val = sat ? $signed({1'b0, {(SHARE_W-1){1'b1}}}) : $signed(quo_reg);
        end
        rsp.done = done_reg;
        rsp.q    = q_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
        ovf_reg <= ovf_next;
        neg_reg <= neg_next;
    end

endmodule

// File: sv/weighted_share_normalizer_unit.sv
// Top level of the weighted share normalizer: loading, totals, group store and share emission.
//
//  Channel   Handshake                    Payload
//  load      load_valid / load_ready      wsn_pkg::load_t
//  share     share_valid / share_ready    wsn_pkg::share_t
//  config    psel, penable, pwrite        paddr, pwdata, prdata (zero_band at 0)
//
// A loaded item passes through accept, four radix-16 multiply steps, then store and add.
// An item that is not stored (faulted set or full store) skips the multiply and add steps.
// Each share item goes through a store read, the start of the 32-step bit-serial dividers, the divide and the output.
// Emission starts with a prepare step that forms the total magnitudes and zero-band flags.
// No clearing pass follows reset; the group store is only read where the current set wrote it.
// A stalled share item holds in the output register while the next one is computed.
module weighted_share_normalizer_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wsn_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [wsn_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [wsn_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready,
    input  logic                              load_valid,
    output logic                              load_ready,
    input  wsn_pkg::load_t                    load,
    output logic                              share_valid,
    input  logic                              share_ready,
    output wsn_pkg::share_t                   share
);
    import wsn_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_MUL   = 9'b000000010,
        ST_ADD   = 9'b000000100,
        ST_PREP  = 9'b000001000,
        ST_READ  = 9'b000010000,
        ST_START = 9'b000100000,
        ST_DIV   = 9'b001000000,
        ST_PUT   = 9'b010000000,
        ST_FAULT = 9'b100000000
    } state_t;

    state_t                   state_reg, state_next;
    logic [WEIGHT_W-1:0]      weight_reg, weight_next;
    logic [DIGIT_CNT_W-1:0]   digit_reg, digit_next;
    logic signed [PWR_W-1:0]  pa_reg, pa_next;
    logic signed [PWR_W-1:0]  pr_reg, pr_next;
    logic signed [PROD_W-1:0] acc_a_reg, acc_a_next;
    logic signed [PROD_W-1:0] acc_r_reg, acc_r_next;
    logic                     last_reg, last_next;
    logic [TOT_W-1:0]         band_reg, band_next;
    logic signed [TOT_W-1:0]  tot_a_reg, tot_a_next;
    logic signed [TOT_W-1:0]  tot_r_reg, tot_r_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [PHASE_W-1:0]       phase_reg, phase_next;
    logic                     fault_reg, fault_next;
    logic [CNT_W-1:0]         idx_reg, idx_next;
    logic [TOT_W-1:0]         da_reg, da_next;
    logic [TOT_W-1:0]         dr_reg, dr_next;
    logic                     za_reg, za_next;
    logic                     zr_reg, zr_next;
    logic                     out_valid_reg, out_valid_next;
    share_t                   out_reg, out_next;

    logic                     accept;
    logic                     first;
    logic                     bad_phase;
    logic                     full;
    logic                     slot_free;
    logic [DIGIT_W-1:0]       digit;
    logic signed [PART_W-1:0] part_a;
    logic signed [PART_W-1:0] part_r;
    logic [REG_IDX_W-1:0]     reg_idx;
    logic                     ram_we;
    logic                     ram_re;
    logic [STORE_W-1:0]       ram_rdata;
    logic signed [PROD_W-1:0] prod_a;
    logic signed [PROD_W-1:0] prod_r;
    div_req_t                 req_a;
    div_req_t                 req_r;
    div_rsp_t                 rsp_a;
    div_rsp_t                 rsp_r;

    assign pready      = 1'b1;
    assign reg_idx     = paddr[CFG_ADDR_W-1:REG_SHIFT];
    assign prdata      = (reg_idx == REG_ZERO_BAND) ? CFG_DATA_W'(band_reg) : '0;
    assign load_ready  = (state_reg == ST_IDLE);
    assign accept      = load_valid && load_ready;
    assign share_valid = out_valid_reg;
    assign share       = out_reg;
    assign slot_free   = !out_valid_reg || share_ready;

    assign digit  = weight_reg[WEIGHT_W-1 -: DIGIT_W];
    assign part_a = $signed({1'b0, digit}) * pa_reg;
    assign part_r = $signed({1'b0, digit}) * pr_reg;

    assign prod_a = $signed(ram_rdata[STORE_W-1:PROD_W]);
    assign prod_r = $signed(ram_rdata[PROD_W-1:0]);

    assign first     = (count_reg == '0) && !fault_reg;
    assign bad_phase = first && (32'(load.phase) >= PHASE_COUNT);
    assign full      = count_reg >= CNT_W'(MAX_GROUPS);
    assign ram_we    = (state_reg == ST_ADD);
    assign ram_re    = (state_reg == ST_READ);

    always_comb
    begin
        req_a.start   = (state_reg == ST_START);
        req_a.mag     = prod_a[PROD_W-1] ? PROD_W'(-prod_a) : PROD_W'(prod_a);
        req_a.neg     = prod_a[PROD_W-1] != tot_a_reg[TOT_W-1];
        req_a.divisor = da_reg;
        req_r.start   = (state_reg == ST_START);
        req_r.mag     = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);
        req_r.neg     = prod_r[PROD_W-1] != tot_r_reg[TOT_W-1];
        req_r.divisor = dr_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        weight_next    = weight_reg;
        digit_next     = digit_reg;
        pa_next        = pa_reg;
        pr_next        = pr_reg;
        acc_a_next     = acc_a_reg;
        acc_r_next     = acc_r_reg;
        last_next      = last_reg;
        band_next      = band_reg;
        tot_a_next     = tot_a_reg;
        tot_r_next     = tot_r_reg;
        count_next     = count_reg;
        phase_next     = phase_reg;
        fault_next     = fault_reg;
        idx_next       = idx_reg;
        da_next        = da_reg;
        dr_next        = dr_reg;
        za_next        = za_reg;
        zr_next        = zr_reg;
        out_valid_next = out_valid_reg && !share_ready;
        out_next       = out_reg;

        if (psel && penable && pwrite && (reg_idx == REG_ZERO_BAND))
        begin
            band_next = pwdata[TOT_W-1:0];
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    last_next = load.last;
                    if (first)
                    begin
                        phase_next = load.phase;
                    end
                    if (!fault_reg && !bad_phase && !full)
                    begin
                        weight_next = load.weight;
                        pa_next     = load.active_power;
                        pr_next     = load.reactive_power;
                        acc_a_next  = '0;
                        acc_r_next  = '0;
                        digit_next  = '0;
                        state_next  = ST_MUL;
                    end
                    else
                    begin
                        fault_next = 1'b1;
                        if (load.last)
                        begin
                            state_next = ST_FAULT;
                        end
                    end
                end
            end
            ST_MUL:
            begin
                acc_a_next  = (acc_a_reg <<< DIGIT_W) + PROD_W'(part_a);
                acc_r_next  = (acc_r_reg <<< DIGIT_W) + PROD_W'(part_r);
                weight_next = weight_reg << DIGIT_W;
                digit_next  = digit_reg + 1'b1;
                if (digit_reg == DIGIT_CNT_W'(DIGITS - 1))
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                tot_a_next = tot_a_reg + TOT_W'(acc_a_reg);
                tot_r_next = tot_r_reg + TOT_W'(acc_r_reg);
                count_next = count_reg + 1'b1;
                state_next = last_reg ? ST_PREP : ST_IDLE;
            end
            ST_PREP:
            begin
                da_next    = tot_a_reg[TOT_W-1] ? TOT_W'(-tot_a_reg) : TOT_W'(tot_a_reg);
                dr_next    = tot_r_reg[TOT_W-1] ? TOT_W'(-tot_r_reg) : TOT_W'(tot_r_reg);
                za_next    = (da_next <= band_reg) || (da_next == '0);
                zr_next    = (dr_next <= band_reg) || (dr_next == '0);
                idx_next   = '0;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_START;
            end
            ST_START:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (rsp_a.done && rsp_r.done)
                begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                if (slot_free)
                begin
                    out_valid_next          = 1'b1;
                    out_next.group_index    = GIDX_W'(idx_reg);
                    out_next.set_phase      = phase_reg;
                    out_next.active_share   = za_reg ? '0 : rsp_a.q;
                    out_next.reactive_share = zr_reg ? '0 : rsp_r.q;
                    out_next.error          = 1'b0;
                    out_next.last_out       = (CNT_W'(idx_reg + 1'b1) == count_reg);
                    idx_next                = idx_reg + 1'b1;
                    if (CNT_W'(idx_reg + 1'b1) == count_reg)
                    begin
                        tot_a_next = '0;
                        tot_r_next = '0;
                        count_next = '0;
                        fault_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_FAULT:
            begin
                if (slot_free)
                begin
                    out_valid_next          = 1'b1;
                    out_next.group_index    = '0;
                    out_next.set_phase      = phase_reg;
                    out_next.active_share   = '0;
                    out_next.reactive_share = '0;
                    out_next.error          = 1'b1;
                    out_next.last_out       = 1'b1;
                    tot_a_next              = '0;
                    tot_r_next              = '0;
                    count_next              = '0;
                    fault_next              = 1'b0;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            digit_reg     <= '0;
            last_reg      <= 1'b0;
            band_reg      <= '0;
            tot_a_reg     <= '0;
            tot_r_reg     <= '0;
            count_reg     <= '0;
            phase_reg     <= '0;
            fault_reg     <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            digit_reg     <= digit_next;
            last_reg      <= last_next;
            band_reg      <= band_next;
            tot_a_reg     <= tot_a_next;
            tot_r_reg     <= tot_r_next;
            count_reg     <= count_next;
            phase_reg     <= phase_next;
            fault_reg     <= fault_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        weight_reg <= weight_next;
        pa_reg     <= pa_next;
        pr_reg     <= pr_next;
        acc_a_reg  <= acc_a_next;
        acc_r_reg  <= acc_r_next;
        da_reg     <= da_next;
        dr_reg     <= dr_next;
        za_reg     <= za_next;
        zr_reg     <= zr_next;
        out_reg    <= out_next;
    end

    wsn_ram #(
        .WIDTH (STORE_W),
        .DEPTH (MAX_GROUPS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata ({acc_a_reg, acc_r_reg}),
        .re    (ram_re),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    wsn_div u_div_active (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_a),
        .rsp   (rsp_a)
    );

    wsn_div u_div_reactive (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_r),
        .rsp   (rsp_r)
    );

endmodule

// File: sv/wsn_checker.sv
// Port-level checker for the weighted share normalizer, bound to the top level.
module wsn_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            share_valid,
    input logic            share_ready,
    input wsn_pkg::share_t share
);
    import wsn_pkg::*;

    logic [GIDX_W-1:0]  exp_idx_reg, exp_idx_next;
    logic [PHASE_W-1:0] run_phase_reg, run_phase_next;
    logic               mid_run_reg, mid_run_next;

    always_comb
    begin
        exp_idx_next   = exp_idx_reg;
        run_phase_next = run_phase_reg;
        mid_run_next   = mid_run_reg;
        if (share_valid && share_ready)
        begin
            exp_idx_next   = share.last_out ? '0 : GIDX_W'(share.group_index + 1'b1);
            run_phase_next = share.set_phase;
            mid_run_next   = !share.last_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_idx_reg   <= '0;
            run_phase_reg <= '0;
            mid_run_reg   <= 1'b0;
        end
        else
        begin
            exp_idx_reg   <= exp_idx_next;
            run_phase_reg <= run_phase_next;
            mid_run_reg   <= mid_run_next;
        end
    end

    // A stalled item must hold its payload.
    a_share_hold: assert property (@(posedge clk) disable iff (!rst_n)
        share_valid && !share_ready |=> share_valid && $stable(share))
        else $error("share item changed while stalled");

    // Group indexes run from zero in order within each emission.
    a_index_order: assert property (@(posedge clk) disable iff (!rst_n)
        share_valid |-> share.group_index == exp_idx_reg)
        else $error("share group index out of order");

    // An error item stands alone and carries no shares.
    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        share_valid && share.error |-> share.last_out && share.group_index == '0
            && share.active_share == '0 && share.reactive_share == '0)
        else $error("malformed error item");

    // All items of one emission carry the same phase.
    a_phase_steady: assert property (@(posedge clk) disable iff (!rst_n)
        share_valid && mid_run_reg |-> share.set_phase == run_phase_reg)
        else $error("set phase changed within an emission");

endmodule

bind weighted_share_normalizer_unit wsn_checker u_wsn_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .share_valid (share_valid),
    .share_ready (share_ready),
    .share       (share)
);

// File: test/tb_top.sv
// Self-checking testbench of weighted_share_normalizer_unit: directed and random load sets checked against a share predictor.
module tb_top;
    import wsn_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 500;
    localparam int SETTLE_CYCLES = 40;
    localparam logic [TOT_W-1:0] BAND_MAX = '1;

    typedef struct {
        load_t  item;
        bit     has_exp;
        share_t exp;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  load_valid;
    logic                  load_ready;
    load_t                 load;
    logic                  share_valid;
    logic                  share_ready;
    share_t                share;

    share_t   expected_shares[$];
    dir_row_t directed_rows[$];
    int       failures = 0;
    int       cycle_count = 0;
    bit       stall_on = 1'b1;
    bit       sender_idle = 1'b1;
    bit       hold_req = 1'b0;

    longint           prod_active[MAX_GROUPS];
    longint           prod_reactive[MAX_GROUPS];
    longint           sum_active = 0;
    longint           sum_reactive = 0;
    int               groups_held = 0;
    logic [PHASE_W-1:0] phase_held = '0;
    bit               set_bad = 1'b0;
    logic [TOT_W-1:0] band_model = '0;

    weighted_share_normalizer_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .load_valid  (load_valid),
        .load_ready  (load_ready),
        .load        (load),
        .share_valid (share_valid),
        .share_ready (share_ready),
        .share       (share)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [SHARE_W-1:0] share_q16(input longint prod, input longint total);
        longint unsigned d;
        longint unsigned pm;
        longint unsigned q;
        bit              neg;
        d = (total < 0) ? -total : total;
        if (d == 0 || d <= {17'b0, band_model})
            return '0;
        pm = (prod < 0) ? -prod : prod;
        q = (pm << FRAC_W) / d;
        neg = (prod < 0) != (total < 0);
        if (neg)
        begin
            if (q > 64'h8000_0000)
                q = 64'h8000_0000;
            q = -q;
        end
        else if (q > 64'h7FFF_FFFF)
        begin
            q = 64'h7FFF_FFFF;
        end
        return q[SHARE_W-1:0];
    endfunction

    task automatic predict_load(input load_t it, input bit typed_valid, input share_t typed);
        longint pa;
        longint pr;
        share_t r;
        if (groups_held == 0 && !set_bad)
        begin
            phase_held = it.phase;
            if (it.phase >= PHASE_COUNT)
                set_bad = 1'b1;
        end
        if (!set_bad)
        begin
            if (groups_held >= MAX_GROUPS)
            begin
                set_bad = 1'b1;
            end
            else
            begin
                pa = longint'(it.weight) * longint'($signed(it.active_power));
                pr = longint'(it.weight) * longint'($signed(it.reactive_power));
                prod_active[groups_held] = pa;
                prod_reactive[groups_held] = pr;
                sum_active += pa;
                sum_reactive += pr;
                groups_held++;
            end
        end
        if (it.last)
        begin
            if (typed_valid)
            begin
                expected_shares.push_back(typed);
            end
            else if (set_bad)
            begin
                r = '0;
                r.set_phase = phase_held;
                r.error = 1'b1;
                r.last_out = 1'b1;
                expected_shares.push_back(r);
            end
            else
            begin
                for (int k = 0; k < groups_held; k++)
                begin
                    r.group_index = GIDX_W'(k);
                    r.set_phase = phase_held;
                    r.active_share = share_q16(prod_active[k], sum_active);
                    r.reactive_share = share_q16(prod_reactive[k], sum_reactive);
                    r.error = 1'b0;
                    r.last_out = (k == groups_held - 1);
                    expected_shares.push_back(r);
                end
            end
            sum_active = 0;
            sum_reactive = 0;
            groups_held = 0;
            set_bad = 1'b0;
        end
    endtask

    function automatic load_t mk_load(input int ph, input int w, input int ap, input int rp,
                                      input bit lst);
        load_t it;
        it.phase = ph[PHASE_W-1:0];
        it.weight = w[WEIGHT_W-1:0];
        it.active_power = ap[PWR_W-1:0];
        it.reactive_power = rp[PWR_W-1:0];
        it.last = lst;
        return it;
    endfunction

    function automatic share_t mk_share(input int gi, input int ph, input int a, input int r,
                                        input bit e, input bit l);
        share_t s;
        s.group_index = gi[GIDX_W-1:0];
        s.set_phase = ph[PHASE_W-1:0];
        s.active_share = a;
        s.reactive_share = r;
        s.error = e;
        s.last_out = l;
        return s;
    endfunction

    function automatic void add_row(input load_t it, input bit has_exp, input share_t exp);
        dir_row_t row;
        row.item = it;
        row.has_exp = has_exp;
        row.exp = exp;
        directed_rows.push_back(row);
    endfunction

    function automatic logic [PWR_W-1:0] rand_power();
        case ($urandom_range(0, 7))
            0: return 24'h7F_FFFF;
            1: return 24'h80_0000;
            2: return PWR_W'($urandom_range(0, 255));
            3: return -PWR_W'($urandom_range(0, 255));
            default: return PWR_W'($urandom);
        endcase
    endfunction

    function automatic logic [WEIGHT_W-1:0] rand_weight();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return WEIGHT_W'($urandom_range(0, 16'h1000));
            default: return WEIGHT_W'($urandom);
        endcase
    endfunction

    function automatic logic [PHASE_W-1:0] rand_first_phase();
        if ($urandom_range(0, 6) == 0)
            return PHASE_W'($urandom_range(PHASE_COUNT, 7));
        return PHASE_W'($urandom_range(0, PHASE_COUNT - 1));
    endfunction

    task automatic send_item(input load_t it, input bit typed_valid, input share_t typed);
        load <= it;
        load_valid <= 1'b1;
        do @(posedge clk); while (!load_ready);
        predict_load(it, typed_valid, typed);
        if (sender_idle && $urandom_range(0, 3) == 0)
        begin
            load_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    task automatic send_set(input int n, input logic [PHASE_W-1:0] first_phase);
        load_t it;
        for (int k = 0; k < n; k++)
        begin
            it.phase = (k == 0) ? first_phase : PHASE_W'($urandom_range(0, 7));
            it.weight = rand_weight();
            it.active_power = rand_power();
            it.reactive_power = rand_power();
            it.last = (k == n - 1);
            send_item(it, 1'b0, '0);
        end
    endtask

    task automatic wait_idle();
        load_valid <= 1'b0;
        while (expected_shares.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_zero_band(input logic [TOT_W-1:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_ADDR_W'(REG_ZERO_BAND) << REG_SHIFT;
        pwdata <= CFG_DATA_W'(v);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        band_model = v;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata != CFG_DATA_W'(v))
        begin
            $error("zero_band: expected %0d, actual %0d", CFG_DATA_W'(v), prdata);
            failures++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endtask

    always @(posedge clk)
    begin : share_check
        share_t want;
        if (rst_n && share_valid && share_ready)
        begin
            if (expected_shares.size() == 0)
            begin
                $error("share item with none expected, group_index %0d", share.group_index);
                failures++;
            end
            else
            begin
                want = expected_shares.pop_front();
                check_field("group_index", want.group_index, share.group_index);
                check_field("set_phase", want.set_phase, share.set_phase);
                check_field("active_share", want.active_share, share.active_share);
                check_field("reactive_share", want.reactive_share, share.reactive_share);
                check_field("error", want.error, share.error);
                check_field("last_out", want.last_out, share.last_out);
            end
        end
    end

    initial
    begin : share_sink
        share_ready = 1'b1;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                share_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                share_ready <= 1'b1;
            end
            else if (stall_on && $urandom_range(0, 7) == 0)
            begin
                share_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                share_ready <= 1'b1;
            end
            else if ($urandom_range(0, 63) == 0)
            begin
                repeat ($urandom_range(20, 80)) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int               placed;
        int               n;
        logic [TOT_W-1:0] band_val;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        load_valid = 1'b0;
        load = '0;

        add_row(mk_load(0, 16'hFFFF, 24'h7FFFFF, 24'h800000, 1), 1,
                mk_share(0, 0, 32'h10000, 32'h10000, 0, 1));
        add_row(mk_load(1, 0, 123, -77, 1), 1, mk_share(0, 1, 0, 0, 0, 1));
        add_row(mk_load(4, 16'h1234, 5, 5, 1), 1, mk_share(0, 4, 0, 0, 1, 1));
        add_row(mk_load(7, 16'h1000, 100, 100, 0), 0, '0);
        add_row(mk_load(0, 16'h1000, 100, 100, 0), 0, '0);
        add_row(mk_load(2, 16'h1000, 100, 100, 1), 1, mk_share(0, 7, 0, 0, 1, 1));
        add_row(mk_load(3, 1, -1, 1, 1), 1, mk_share(0, 3, 32'h10000, 32'h10000, 0, 1));
        add_row(mk_load(3, 16'h1000, 1, -1, 0), 0, '0);
        add_row(mk_load(6, 16'hFFFF, 8388607, 8388607, 0), 0, '0);
        add_row(mk_load(5, 1, -8388608, 100, 1), 0, '0);
        add_row(mk_load(2, 16'hFFFF, 8388607, -8388608, 0), 0, '0);
        add_row(mk_load(1, 16'hFFFF, -8388607, 8388607, 0), 0, '0);
        add_row(mk_load(0, 1, 1, 65536, 1), 0, '0);
        add_row(mk_load(1, 16'h2000, 1000, -5, 0), 0, '0);
        add_row(mk_load(1, 16'h2000, -1000, 5, 1), 0, '0);
        add_row(mk_load(2, 16'h0800, 3000, -40000, 0), 0, '0);
        add_row(mk_load(0, 16'h8000, -9000, 10000, 1), 0, '0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].has_exp, directed_rows[i].exp);

        for (int p = 0; p < 6; p++)
        begin
            wait_idle();
            case (p)
                0: band_val = '0;
                1: band_val = BAND_MAX;
                2: band_val = TOT_W'({$urandom_range(0, 63), $urandom});
                3: band_val = 1;
                4: band_val = TOT_W'({$urandom_range(0, 255), $urandom});
                default: band_val = '0;
            endcase
            cfg_zero_band(band_val);
            stall_on = (p != 5);
            sender_idle = stall_on;
            if (p == 4)
                hold_req = 1'b1;
            if (p == 0)
                send_set(MAX_GROUPS, PHASE_W'($urandom_range(0, PHASE_COUNT - 1)));
            if (p == 3)
                send_set(MAX_GROUPS + 3, PHASE_W'($urandom_range(0, PHASE_COUNT - 1)));
            placed = 0;
            while (placed < 20)
            begin
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
                sender_idle = stall_on && ($urandom_range(0, 2) != 0);
                send_set(n, rand_first_phase());
                placed += n;
            end
        end

        load_valid <= 1'b0;
        while (expected_shares.size() != 0)
            @(posedge clk);
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: filelist.f
sv/wsn_pkg.sv
sv/wsn_ram.sv
sv/wsn_div.sv
sv/weighted_share_normalizer_unit.sv
sv/wsn_checker.sv
test/tb_top.sv
